### hw/rtl/frt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frt_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_FRAG_BYTES_LOG2 = 10;
	localparam int DEF_MAX_FRAGS       = 1024;

	// Field widths of the transactions.
	localparam int OFFSET_W = 20;
	localparam int LENGTH_W = 21;
	localparam int FIDX_W   = 22;

	// Reset value of the file length register.
	localparam logic [LENGTH_W-1:0] FILE_BYTES_RESET = 21'd1024;

	// Register indexes of the configuration port.
	localparam logic REG_FILE_BYTES    = 1'b0;
	localparam logic REG_DOWNLOAD_MODE = 1'b1;

	// Input commands.
	localparam logic [1:0] CMD_REQ_TICK   = 2'd0;
	localparam logic [1:0] CMD_SERVE_TICK = 2'd1;
	localparam logic [1:0] CMD_REQ_RCVD   = 2'd2;
	localparam logic [1:0] CMD_FRAG_RCVD  = 2'd3;

	// Kinds of message sent.
	localparam logic [1:0] SEND_NONE = 2'd0;
	localparam logic [1:0] SEND_REQ  = 2'd1;
	localparam logic [1:0] SEND_FRAG = 2'd2;

	// One result transaction.
	typedef struct packed {
		logic                download_done;
		logic [LENGTH_W-1:0] send_length;
		logic [OFFSET_W-1:0] send_offset;
		logic [1:0]          send_kind;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/frt_bitmap_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Fragment state memory: bit 1 is held, bit 0 is wanted. One write port and
// one read port with registered read data.
module frt_bitmap_ram #(
	parameter int DEPTH = frt_pkg::DEF_MAX_FRAGS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [1:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [1:0]    rdata
);

	logic [1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered: read data follows in the cycle after re.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/frt_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: walks the fragment memory one entry per read and evaluate pair,
// performs the read-modify-write of each command and holds the result.
module frt_seq #(
	parameter int FRAG_BYTES_LOG2 = frt_pkg::DEF_FRAG_BYTES_LOG2,
	parameter int MAX_FRAGS       = frt_pkg::DEF_MAX_FRAGS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [frt_pkg::LENGTH_W-1:0]  file_bytes,
	input  wire logic                          download_mode,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    in_cmd,
	input  wire logic [frt_pkg::OFFSET_W-1:0]  in_offset,
	input  wire logic [frt_pkg::LENGTH_W-1:0]  in_length,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output frt_pkg::result_t                   out_res
);

	localparam int L     = FRAG_BYTES_LOG2;
	localparam int IDX_W = $clog2(MAX_FRAGS);
	localparam int CNT_W = $clog2(MAX_FRAGS + 1);
	localparam int FW    = frt_pkg::FIDX_W;
	localparam int LW    = frt_pkg::LENGTH_W;
	localparam int BW    = ((CNT_W + L) > LW ? (CNT_W + L) : LW) + 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_EV    = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]       state_q;
	logic [1:0]       cmd_q;
	logic             phase_q;
	logic [CNT_W-1:0] cur_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] start_q;
	logic [CNT_W-1:0] n_q;
	logic [FW-1:0]    end_q;
	logic [IDX_W-1:0] ptr_q;
	logic             done_given_q;
	logic             ov_q;
	frt_pkg::result_t res_q;
	frt_pkg::result_t out_q;
	frt_pkg::result_t fin_res;

	logic             ram_we;
	logic [1:0]       ram_wdata;
	logic             ram_re;
	logic [1:0]       ram_rdata;
	logic [IDX_W-1:0] cur_addr;

	frt_bitmap_ram #(
		.DEPTH(MAX_FRAGS),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cur_addr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(cur_addr),
		.rdata(ram_rdata)
	);

	assign cur_addr = cur_q[IDX_W-1:0];

	// Fragment count from the file length, saturated.
	logic [LW-1:0]    quot;
	logic [CNT_W-1:0] n_now;
	always_comb begin
		quot = ((file_bytes - LW'(1)) >> L) + LW'(1);
		if (file_bytes == '0) begin
			n_now = '0;
		end else if (quot > LW'(MAX_FRAGS)) begin
			n_now = CNT_W'(MAX_FRAGS);
		end else begin
			n_now = quot[CNT_W-1:0];
		end
	end

	// Decode of a received request or fragment.
	logic [FW-1:0] first;
	logic [FW-1:0] cnt;
	logic [FW-1:0] n_ext;
	logic [CNT_W-1:0] base;
	always_comb begin
		first = {{(FW - frt_pkg::OFFSET_W){1'b0}}, in_offset} >> L;
		cnt   = ({1'b0, in_length} + (FW'(1) << L) - FW'(1)) >> L;
		n_ext = {{(FW - CNT_W){1'b0}}, n_now};
		base  = (CNT_W'(ptr_q) < n_now) ? CNT_W'(ptr_q) : '0;
	end

	// Memory read data as seen by the commands.
	logic             held_eff;
	logic [CNT_W-1:0] nxt;
	logic             last;
	assign held_eff = !download_mode || ram_rdata[1];
	assign nxt      = cur_q + CNT_W'(1);
	assign last     = (nxt >= n_q);

	// Offsets and lengths of the two message kinds.
	logic [CNT_W-1:0] sel_start;
	logic [CNT_W-1:0] sel_stop;
	logic [BW-1:0]    fb_ext;
	logic [BW-1:0]    fsize;
	logic [BW-1:0]    req_off;
	logic [BW-1:0]    req_len;
	logic [BW-1:0]    frag_off;
	logic [BW-1:0]    frag_rem;
	logic [BW-1:0]    frag_len;
	always_comb begin
		sel_start = phase_q ? start_q : cur_q;
		sel_stop  = (phase_q && held_eff) ? cur_q : n_q;
		fb_ext    = {{(BW - LW){1'b0}}, file_bytes};
		fsize     = BW'(1) << L;
		req_off   = {{(BW - CNT_W){1'b0}}, sel_start} << L;
		req_len   = {{(BW - CNT_W){1'b0}}, sel_stop - sel_start} << L;
		if (req_off + req_len > fb_ext) begin
			req_len = fb_ext - req_off;
		end
		frag_off = {{(BW - CNT_W){1'b0}}, cur_q} << L;
		frag_rem = fb_ext - frag_off;
		frag_len = (frag_rem > fsize) ? fsize : frag_rem;
	end

	// Memory write and read controls.
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = 2'b00;
		ram_re    = (state_q == ST_RD);
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_EV) begin
			unique case (cmd_q)
				frt_pkg::CMD_SERVE_TICK: begin
					ram_we    = ram_rdata[0];
					ram_wdata = {ram_rdata[1], 1'b0};
				end
				frt_pkg::CMD_REQ_RCVD: begin
					ram_we    = held_eff;
					ram_wdata = {ram_rdata[1], 1'b1};
				end
				frt_pkg::CMD_FRAG_RCVD: begin
					ram_we    = !phase_q;
					ram_wdata = {ram_rdata[1] | download_mode, 1'b0};
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_res   = out_q;

	// Result of the command being finished in this cycle.
	always_comb begin
		fin_res = '0;
		if (state_q == ST_EV) begin
			unique case (cmd_q)
				frt_pkg::CMD_REQ_TICK: begin
					if ((!phase_q && !held_eff && last) || (phase_q && (held_eff || last))) begin
						fin_res.send_kind   = frt_pkg::SEND_REQ;
						fin_res.send_offset = req_off[frt_pkg::OFFSET_W-1:0];
						fin_res.send_length = req_len[LW-1:0];
					end
				end
				frt_pkg::CMD_SERVE_TICK: begin
					if (ram_rdata[0]) begin
						fin_res.send_kind   = frt_pkg::SEND_FRAG;
						fin_res.send_offset = frag_off[frt_pkg::OFFSET_W-1:0];
						fin_res.send_length = frag_len[LW-1:0];
					end
				end
				frt_pkg::CMD_FRAG_RCVD: begin
					fin_res.download_done = phase_q && held_eff && last;
				end
				default: begin
					fin_res = '0;
				end
			endcase
		end
	end

	// Output register: takes the finished result once the previous one has gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			out_q <= '0;
		end else if (state_q == ST_OUT && (!ov_q || out_ready)) begin
			ov_q  <= 1'b1;
			out_q <= res_q;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	// Command sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cur_q        <= '0;
			ptr_q        <= '0;
			done_given_q <= 1'b0;
			phase_q      <= 1'b0;
			cmd_q        <= frt_pkg::CMD_REQ_TICK;
			k_q          <= '0;
			start_q      <= '0;
			n_q          <= '0;
			end_q        <= '0;
			res_q        <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cur_q <= nxt;
					if (cur_q == CNT_W'(MAX_FRAGS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_cmd;
						n_q     <= n_now;
						phase_q <= 1'b0;
						k_q     <= '0;
						end_q   <= first + cnt;
						res_q   <= '0;
						state_q <= ST_OUT;
						unique case (in_cmd)
							frt_pkg::CMD_REQ_TICK: begin
								cur_q <= '0;
								if (n_now != '0) state_q <= ST_RD;
							end
							frt_pkg::CMD_SERVE_TICK: begin
								cur_q <= base;
								if (n_now != '0) state_q <= ST_RD;
							end
							frt_pkg::CMD_REQ_RCVD: begin
								cur_q <= first[CNT_W-1:0];
								if (first < n_ext && cnt != '0) state_q <= ST_RD;
							end
							default: begin
								cur_q <= first[CNT_W-1:0];
								if (first < n_ext) state_q <= ST_RD;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					res_q   <= fin_res;
					state_q <= ST_OUT;
					unique case (cmd_q)
						frt_pkg::CMD_REQ_TICK: begin
							if (!phase_q) begin
								if (!held_eff) begin
									start_q <= cur_q;
									phase_q <= 1'b1;
								end
								if (!last) begin
									cur_q   <= nxt;
									state_q <= ST_RD;
								end
							end else if (!held_eff && !last) begin
								cur_q   <= nxt;
								state_q <= ST_RD;
							end
						end
						frt_pkg::CMD_SERVE_TICK: begin
							if (ram_rdata[0]) begin
								ptr_q <= cur_addr;
							end else if (k_q + CNT_W'(1) < n_q) begin
								k_q     <= k_q + CNT_W'(1);
								cur_q   <= last ? '0 : nxt;
								state_q <= ST_RD;
							end
						end
						frt_pkg::CMD_REQ_RCVD: begin
							if (!last && {{(FW - CNT_W){1'b0}}, nxt} < end_q) begin
								cur_q   <= nxt;
								state_q <= ST_RD;
							end
						end
						default: begin
							if (!phase_q) begin
								// A newly held fragment starts a check for completion.
								if (!held_eff && !done_given_q) begin
									phase_q <= 1'b1;
									cur_q   <= '0;
									state_q <= ST_RD;
								end
							end else if (held_eff) begin
								if (last) begin
									done_given_q <= 1'b1;
								end else begin
									cur_q   <= nxt;
									state_q <= ST_RD;
								end
							end
						end
					endcase
				end
				ST_OUT: begin
					if (!ov_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/fragment_request_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake              | Content
// s_axis   | in  | s_axis_tvalid/tready   | tuser cmd, tdata offset and length
// m_axis   | out | m_axis_tvalid/tready   | tuser kind/done, tdata offset/length
// cfg      | in  | cfg_we, no wait        | index 0 file_bytes, 1 download_mode
//
// Every entry visited takes a memory read, then an evaluate and write.
// A request or serve tick visits up to frag_count entries; a fragment that
// completes a hold visits up to frag_count + 1; before that the item is
// accepted, and afterwards its result is handed to the output register.
// After reset a clearing pass writes all MAX_FRAGS entries before s_axis_tready.
// One finished result waits in the output register while the next item runs;
// the next result stalls only while that register is still full.
module fragment_request_tracker #(
	parameter int FRAG_BYTES_LOG2 = frt_pkg::DEF_FRAG_BYTES_LOG2,
	parameter int MAX_FRAGS       = frt_pkg::DEF_MAX_FRAGS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // msg_offset[19:0], msg_length[40:20]
	input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // send_offset[19:0], send_length[40:20]
	output logic [2:0]       m_axis_tuser,   // send_kind[1:0], download_done[2]
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [20:0] cfg_wdata
);

	logic [frt_pkg::LENGTH_W-1:0] file_bytes_q;
	logic                         download_mode_q;
	frt_pkg::result_t             res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_bytes_q    <= frt_pkg::FILE_BYTES_RESET;
			download_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frt_pkg::REG_FILE_BYTES:    file_bytes_q    <= cfg_wdata;
				frt_pkg::REG_DOWNLOAD_MODE: download_mode_q <= cfg_wdata[0];
				default:                    file_bytes_q    <= file_bytes_q;
			endcase
		end
	end

	frt_seq #(
		.FRAG_BYTES_LOG2(FRAG_BYTES_LOG2),
		.MAX_FRAGS      (MAX_FRAGS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.file_bytes   (file_bytes_q),
		.download_mode(download_mode_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_cmd       (s_axis_tuser),
		.in_offset    (s_axis_tdata[19:0]),
		.in_length    (s_axis_tdata[40:20]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_res      (res)
	);

	// Result packing.
	assign m_axis_tdata = {7'd0, res.send_length, res.send_offset};
	assign m_axis_tuser = {res.download_done, res.send_kind};

endmodule

`default_nettype wire

### hw/rtl/frt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module frt_checker #(
	parameter int FRAG_BYTES_LOG2 = frt_pkg::DEF_FRAG_BYTES_LOG2
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata,
	input wire logic [2:0]  m_axis_tuser
);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A silent result carries no offset or length.
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == frt_pkg::SEND_NONE
		|-> m_axis_tdata[40:0] == '0)
		else $error("empty result with payload");

	// Completion is reported only on a result that sends nothing.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == frt_pkg::SEND_NONE)
		else $error("done on a send");

	// A served fragment is never longer than one fragment and never empty.
	a_frag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == frt_pkg::SEND_FRAG
		|-> m_axis_tdata[40:20] != '0 && m_axis_tdata[40:20] <= (21'd1 << FRAG_BYTES_LOG2))
		else $error("bad fragment length");

	// The item is not taken while the block is still busy with the last one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted two items back to back");

endmodule

bind fragment_request_tracker frt_checker #(
	.FRAG_BYTES_LOG2(FRAG_BYTES_LOG2)
) u_frt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
